/* rtl/hed_pkg.sv */
// ----------------------------------------------------------------------------
// HTML character reference decoder package
// Shared constants and types: delimiter characters, parse kinds and the
// default sizes of the name table.
// ----------------------------------------------------------------------------
package hed_pkg;

    // Default sizes of the name table and the digit limit.
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_NAME_CHARS  = 8;
    localparam int DEF_MAX_DIGITS  = 31;

    // Fixed field widths of the item ports.
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int ENAME_W  = 64;
    localparam int ECODE_W  = 21;
    localparam int CODEPT_W = 31;

    // Parse state widths.
    localparam int BCOUNT_W = 6;
    localparam int DCOUNT_W = 7;
    localparam int ACCUM_W  = 32;

    // Characters that shape a reference.
    localparam logic [BYTE_W-1:0] CHAR_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CHAR_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_LOW_X  = 8'h78;
    localparam logic [BYTE_W-1:0] CHAR_HIGH_X = 8'h58;

    // Largest value a numeric reference may carry, and the saturated value.
    localparam logic [ACCUM_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [ACCUM_W-1:0] VALUE_SAT = 32'h8000_0000;

    // Item operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // What the reference turned out to be after its second byte (hex after its third).
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_NAMED = 2'd1,
        KIND_DEC   = 2'd2,
        KIND_HEX   = 2'd3
    } parse_kind_t;

endpackage

/* rtl/html_entity_decoder_core.sv */
// ----------------------------------------------------------------------------
// HTML character reference decoder core
// Decodes one character reference, fed byte by byte, into a code point.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_*) carries two kinds of transfer. A load (s_op = 0)
// writes one slot of the entity name table. A byte (s_op = 1) delivers one
// byte of a reference; s_is_last marks its final byte. Each final byte gives
// exactly one transfer on the result channel (m_*): m_found and m_code_point.
// Loads and other bytes give no result.
// A numeric reference, or any reference that fails its syntax checks, has
// its result in the output register in the cycle after the final byte.
// A named reference scans the table through its single read port, one slot
// per cycle from slot 0, stopping at the first match. No transfer is taken
// during the scan.
// After reset the block sweeps the table, clearing one slot per cycle, and
// s_ready stays low meanwhile.
// The output register lets new bytes and loads in while a result waits;
// only a final byte is held off until the waiting result has been taken.
// ----------------------------------------------------------------------------
module html_entity_decoder_core
    import hed_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_CHARS  = DEF_NAME_CHARS,
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [BYTE_W-1:0]   s_ref_byte,
    input  logic                s_is_last,
    input  logic [INDEX_W-1:0]  s_entry_index,
    input  logic [ENAME_W-1:0]  s_entry_name,
    input  logic [ECODE_W-1:0]  s_entry_code,
    input  logic                s_entry_valid,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [CODEPT_W-1:0] m_code_point
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = 8 * NAME_CHARS;
    localparam int WW = 1 + ECODE_W + NW;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Table memory: {used, code, name} per slot.
    logic [WW-1:0] table_mem [TABLE_DEPTH];
    logic [WW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [AW-1:0]         scan_addr_reg, scan_addr_next;
    logic                  scan_issue_reg, scan_issue_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  rd_last_reg, rd_last_next;

    logic [BCOUNT_W-1:0]   byte_cnt_reg, byte_cnt_next;
    parse_kind_t           kind_reg, kind_next;
    logic [ACCUM_W-1:0]    accum_reg, accum_next;
    logic [DCOUNT_W-1:0]   digit_cnt_reg, digit_cnt_next;
    logic [NW-1:0]         name_reg, name_next;
    logic                  reject_reg, reject_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg, m_found_next;
    logic [CODEPT_W-1:0]   m_code_reg, m_code_next;

    logic                  accept;
    logic                  load_in_range;
    logic                  final_ok;
    logic                  is_hex;
    logic [4:0]            dval;
    logic [DCOUNT_W-1:0]   cnt_inc;
    logic [ACCUM_W+3:0]    prod;
    logic [ACCUM_W+3:0]    dsum;
    logic [BCOUNT_W-1:0]   name_pos;
    logic                  rd_used;
    logic [ECODE_W-1:0]    rd_code;
    logic [NW-1:0]         rd_name;

    // Value of a digit character in base 16; 16 marks a non-digit.
    function automatic logic [4:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    assign s_ready = (state_reg == ST_IDLE) &&
                     (!(s_op && s_is_last) || !m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_code_point = m_code_reg;

    assign rd_used = rd_data_reg[WW-1];
    assign rd_code = rd_data_reg[NW +: ECODE_W];
    assign rd_name = rd_data_reg[NW-1:0];

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[scan_addr_reg];
    end

    // Next-state logic for the sweep, the parser and the table scan.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        scan_issue_next = scan_issue_reg;
        rd_valid_next   = rd_valid_reg;
        rd_last_next    = rd_last_reg;
        byte_cnt_next   = byte_cnt_reg;
        kind_next       = kind_reg;
        accum_next      = accum_reg;
        digit_cnt_next  = digit_cnt_reg;
        name_next       = name_reg;
        reject_next     = reject_reg;
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_code_next     = m_code_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;

        load_in_range = 32'(s_entry_index) < 32'(TABLE_DEPTH);
        final_ok      = !reject_reg && (byte_cnt_reg >= BCOUNT_W'(2)) &&
                        (s_ref_byte == CHAR_SEMI);
        is_hex        = (kind_reg == KIND_HEX);
        dval          = digit_value(s_ref_byte);
        cnt_inc       = (digit_cnt_reg != {DCOUNT_W{1'b1}}) ?
                        digit_cnt_reg + DCOUNT_W'(1) : digit_cnt_reg;
        prod          = is_hex ? {accum_reg, 4'h0} :
                        ({1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0});
        dsum          = prod + (ACCUM_W + 4)'(dval);
        name_pos      = (byte_cnt_reg == BCOUNT_W'(1)) ? '0 :
                        byte_cnt_reg - BCOUNT_W'(1);

        // The waiting result leaves on its transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // Sweep after reset marks every slot unused.
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept && s_op == OP_LOAD) begin
                    // Table load; slots beyond the table are dropped.
                    if (load_in_range) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(s_entry_index);
                        mem_wdata = {s_entry_valid, s_entry_code, s_entry_name[NW-1:0]};
                    end
                end else if (accept && !s_is_last) begin
                    // Body byte of a reference.
                    if (byte_cnt_reg == '0) begin
                        if (s_ref_byte != CHAR_AMP) begin
                            reject_next = 1'b1;
                        end
                    end else if (byte_cnt_reg == BCOUNT_W'(1) && s_ref_byte == CHAR_HASH) begin
                        kind_next = KIND_DEC;
                    end else if (byte_cnt_reg == BCOUNT_W'(1) || kind_reg == KIND_NAMED) begin
                        kind_next = KIND_NAMED;
                        for (int k = 0; k < NAME_CHARS; k++) begin
                            if (name_pos == BCOUNT_W'(k)) begin
                                name_next[8*k +: 8] = name_reg[8*k +: 8] | s_ref_byte;
                            end
                        end
                    end else if (kind_reg == KIND_DEC && byte_cnt_reg == BCOUNT_W'(2) &&
                                 (s_ref_byte == CHAR_LOW_X || s_ref_byte == CHAR_HIGH_X)) begin
                        kind_next = KIND_HEX;
                    end else if (dval >= (is_hex ? 5'd16 : 5'd10)) begin
                        reject_next = 1'b1;
                    end else begin
                        digit_cnt_next = cnt_inc;
                        if (cnt_inc > DCOUNT_W'(MAX_DIGITS)) begin
                            reject_next = 1'b1;
                        end
                        if (dsum > (ACCUM_W + 4)'(VALUE_MAX)) begin
                            accum_next = VALUE_SAT;
                        end else begin
                            accum_next = dsum[ACCUM_W-1:0];
                        end
                    end
                    if (byte_cnt_reg != {BCOUNT_W{1'b1}}) begin
                        byte_cnt_next = byte_cnt_reg + BCOUNT_W'(1);
                    end
                end else if (accept) begin
                    // Final byte: settle the result or start the table scan.
                    byte_cnt_next  = '0;
                    kind_next      = KIND_NONE;
                    accum_next     = '0;
                    digit_cnt_next = '0;
                    reject_next    = 1'b0;
                    if (final_ok && kind_reg == KIND_NAMED &&
                        {1'b0, byte_cnt_reg} <= (BCOUNT_W + 1)'(NAME_CHARS + 1)) begin
                        state_next      = ST_SCAN;
                        scan_addr_next  = '0;
                        scan_issue_next = 1'b1;
                        rd_valid_next   = 1'b0;
                        rd_last_next    = 1'b0;
                    end else begin
                        name_next    = '0;
                        m_valid_next = 1'b1;
                        if (final_ok && (kind_reg == KIND_DEC || kind_reg == KIND_HEX) &&
                            digit_cnt_reg != '0 && !accum_reg[ACCUM_W-1]) begin
                            m_found_next = 1'b1;
                            m_code_next  = accum_reg[CODEPT_W-1:0];
                        end else begin
                            m_found_next = 1'b0;
                            m_code_next  = '0;
                        end
                    end
                end
            end

            // Table scan: issue one read per cycle, compare the one before.
            ST_SCAN: begin
                rd_valid_next = scan_issue_reg;
                rd_last_next  = (scan_addr_reg == LAST_SLOT);
                if (scan_issue_reg) begin
                    scan_addr_next = scan_addr_reg + AW'(1);
                    if (scan_addr_reg == LAST_SLOT) begin
                        scan_issue_next = 1'b0;
                    end
                end
                if (rd_valid_reg && rd_used && rd_name == name_reg) begin
                    state_next   = ST_IDLE;
                    name_next    = '0;
                    m_valid_next = 1'b1;
                    m_found_next = 1'b1;
                    m_code_next  = CODEPT_W'(rd_code);
                end else if (rd_valid_reg && rd_last_reg) begin
                    state_next   = ST_IDLE;
                    name_next    = '0;
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_code_next  = '0;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            scan_issue_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            byte_cnt_reg   <= '0;
            kind_reg       <= KIND_NONE;
            accum_reg      <= '0;
            digit_cnt_reg  <= '0;
            name_reg       <= '0;
            reject_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            scan_addr_reg  <= scan_addr_next;
            scan_issue_reg <= scan_issue_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            byte_cnt_reg   <= byte_cnt_next;
            kind_reg       <= kind_next;
            accum_reg      <= accum_next;
            digit_cnt_reg  <= digit_cnt_next;
            name_reg       <= name_next;
            reject_reg     <= reject_next;
            m_valid_reg    <= m_valid_next;
        end
        m_found_reg <= m_found_next;
        m_code_reg  <= m_code_next;
    end

endmodule
